// ===== sv/aopt_pkg.sv =====
// Package for the altitude observer and thrust controller: constants, codes and helpers.
`timescale 1ns / 1ps
`default_nettype none

package aopt_pkg;

  // Fixed-point format of every value in the block.
  localparam int FRAC_BITS = 16;

  // Field widths.
  localparam int RANGE_W = 20;
  localparam int TILT_W  = 18;
  localparam int SP_W    = 21;
  localparam int THR_W   = 24;
  localparam int EST_W   = 32;
  localparam int GAIN_W  = 24;
  localparam int DT_W    = 16;
  localparam int IN_W    = 64;
  localparam int OUT_W   = 88;
  localparam int IDX_W   = 3;

  // Serial multiplier: signed multiplicand, unsigned multiplier taken a digit a cycle.
  localparam int A_W     = 58 - FRAC_BITS;
  localparam int B_W     = GAIN_W;
  localparam int DIGIT_W = 4;
  localparam int NDIG    = B_W / DIGIT_W;
  localparam int CNT_W   = $clog2(NDIG);
  localparam int HI_W    = A_W + 2;
  localparam int SUM_W   = HI_W + DIGIT_W + 1;
  localparam int R_W     = HI_W + B_W;
  localparam int PID_W   = R_W + 2;

  // Setpoint shaping: truncating divide by five through a reciprocal.
  localparam int REF_W      = 26;
  localparam int DIV5_SHIFT = 24;
  localparam logic [21:0] DIV5_MUL = 22'd3355444;

  localparam logic signed [31:0] GRAV_Q =
    32'((981 * (64'sd1 <<< FRAC_BITS) + 64'sd50) / 64'sd100);

  // Register indexes.
  localparam logic [IDX_W-1:0] REG_POSITION_GAIN          = 3'd0;
  localparam logic [IDX_W-1:0] REG_INTEGRAL_GAIN          = 3'd1;
  localparam logic [IDX_W-1:0] REG_VELOCITY_GAIN          = 3'd2;
  localparam logic [IDX_W-1:0] REG_VEHICLE_MASS           = 3'd3;
  localparam logic [IDX_W-1:0] REG_INVERSE_MASS           = 3'd4;
  localparam logic [IDX_W-1:0] REG_OBSERVER_POSITION_GAIN = 3'd5;
  localparam logic [IDX_W-1:0] REG_OBSERVER_VELOCITY_GAIN = 3'd6;
  localparam logic [IDX_W-1:0] REG_TIME_STEP              = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_WB,
    ST_DONE
  } state_t;

  // One product per step, in the order the tick needs them.
  typedef enum logic [3:0] {
    STEP_ZM,
    STEP_PRED_H,
    STEP_PRED_ACC,
    STEP_PRED_V,
    STEP_COR_V,
    STEP_COR_H,
    STEP_INT,
    STEP_KP,
    STEP_KI,
    STEP_KD,
    STEP_MASS
  } step_t;

  function automatic logic signed [31:0] sat32(input logic signed [PID_W-1:0] v);
    logic signed [PID_W-1:0] lim_hi;
    logic signed [PID_W-1:0] lim_lo;
    lim_hi = PID_W'(32'sh7fff_ffff);
    lim_lo = PID_W'($signed(32'h8000_0000));
    if (v > lim_hi) begin
      sat32 = 32'sh7fff_ffff;
    end else if (v < lim_lo) begin
      sat32 = $signed(32'h8000_0000);
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  function automatic logic signed [THR_W-1:0] sat24(input logic signed [PID_W-1:0] v);
    logic signed [PID_W-1:0] lim_hi;
    logic signed [PID_W-1:0] lim_lo;
    lim_hi = PID_W'(24'sh7f_ffff);
    lim_lo = PID_W'($signed(24'h80_0000));
    if (v > lim_hi) begin
      sat24 = 24'sh7f_ffff;
    end else if (v < lim_lo) begin
      sat24 = $signed(24'h80_0000);
    end else begin
      sat24 = v[THR_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== sv/altitude_observer_pid_thrust.sv =====
// Top level: altitude observer and PID thrust controller around one digit-serial multiplier.
`timescale 1ns / 1ps
`default_nettype none

// One input beat is one control tick. The block predicts height and climb rate from the
// previous thrust, corrects both against the tilt-compensated range, updates the integral
// error and returns one output beat with the saturated thrust and both estimates. All
// arithmetic is signed fixed point with FRAC_BITS fraction bits; every product is rounded
// half up. The eleven products of a tick share a single multiplier that consumes its
// unsigned operand four bits per cycle, so each product passes through a load step, the
// digit steps and a write-back step. A new beat is accepted only once the previous tick
// has been handed to the output register. The output register lets the next beat be
// accepted while the previous result still waits for the sink. Configuration writes are
// taken at any time but should only be made while the block is idle.
module altitude_observer_pid_thrust (
  input  wire                          clk,
  input  wire                          rst,
  // tdata, lowest bit up: range_reading[19:0], tilt_cosine[37:20],
  // altitude_setpoint[58:38], zero padding[63:59]
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire  [aopt_pkg::IN_W-1:0]    s_tdata,
  // tdata, lowest bit up: thrust[23:0], altitude_estimate[55:24],
  // velocity_estimate[87:56]
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [aopt_pkg::OUT_W-1:0]   m_tdata,
  input  wire                          cfg_we,
  input  wire  [aopt_pkg::IDX_W-1:0]   cfg_index,
  input  wire  [aopt_pkg::GAIN_W-1:0]  cfg_data
);
  import aopt_pkg::*;

  localparam logic signed [HI_W-1:0]  HALF_HI  = HI_W'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [REF_W-1:0] HALF_REF = REF_W'(64'sd1 <<< (FRAC_BITS - 1));

  // Configuration registers.
  logic [GAIN_W-1:0] position_gain;
  logic [GAIN_W-1:0] integral_gain;
  logic [GAIN_W-1:0] velocity_gain;
  logic [GAIN_W-1:0] vehicle_mass;
  logic [GAIN_W-1:0] inverse_mass;
  logic [GAIN_W-1:0] observer_position_gain;
  logic [GAIN_W-1:0] observer_velocity_gain;
  logic [DT_W-1:0]   time_step;

  // Filter and controller state carried from tick to tick.
  logic signed [31:0]      height;
  logic signed [31:0]      climb_rate;
  logic signed [31:0]      error_integral;
  logic signed [THR_W-1:0] previous_thrust;

  // Per-tick working registers.
  logic [RANGE_W-1:0]        range_q;
  logic signed [TILT_W-1:0]  tilt_q;
  logic signed [SP_W-1:0]    sp_q;
  logic signed [REF_W-1:0]   ref_q;
  logic signed [A_W-1:0]     zm;
  logic signed [A_W-1:0]     accel;
  logic signed [PID_W-1:0]   pid;
  logic signed [THR_W-1:0]   thrust_q;

  // Multiplier registers.
  logic signed [A_W-1:0]  mul_a;
  logic [B_W-1:0]         mul_b;
  logic signed [HI_W-1:0] hi;
  logic [B_W-1:0]         lo;
  logic [CNT_W-1:0]       dig_cnt;

  state_t state;
  state_t state_next;
  step_t  step;

  logic in_fire;
  logic out_free;

  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  // No beat is taken while reset is held.
  assign s_tready = (state == ST_IDLE) && !rst;

  // Setpoint shaping: above half a metre the excess is divided by five, truncated.
  logic signed [REF_W-1:0] sp_ext;
  logic signed [REF_W-1:0] sp_off;
  logic [42:0]             ref_prod;
  logic signed [REF_W-1:0] ref_comb;

  always_comb begin
    sp_ext   = REF_W'(sp_q);
    sp_off   = sp_ext - HALF_REF;
    ref_prod = 43'(sp_off[20:0]) * 43'(DIV5_MUL);
    if (sp_ext > HALF_REF) begin
      ref_comb = HALF_REF + REF_W'($signed({1'b0, ref_prod[42:DIV5_SHIFT]}));
    end else begin
      ref_comb = sp_ext;
    end
  end

  // Innovation and altitude error, formed when the product that needs them is loaded.
  logic signed [PID_W-1:0] innov_w;
  logic signed [PID_W-1:0] err_w;

  assign innov_w = PID_W'(zm) - PID_W'(height);
  assign err_w   = PID_W'(ref_q) - PID_W'(height);

  // Operand selection for the product of the current step.
  logic signed [A_W-1:0] a_sel;
  logic [B_W-1:0]        b_sel;

  always_comb begin
    a_sel = A_W'(climb_rate);
    b_sel = B_W'(time_step);
    case (step)
      STEP_ZM: begin
        a_sel = A_W'(tilt_q);
        b_sel = B_W'(range_q);
      end
      STEP_PRED_H: begin
        a_sel = A_W'(climb_rate);
        b_sel = B_W'(time_step);
      end
      STEP_PRED_ACC: begin
        a_sel = A_W'(previous_thrust);
        b_sel = inverse_mass;
      end
      STEP_PRED_V: begin
        a_sel = accel;
        b_sel = B_W'(time_step);
      end
      STEP_COR_V: begin
        a_sel = innov_w[A_W-1:0];
        b_sel = observer_velocity_gain;
      end
      STEP_COR_H: begin
        a_sel = innov_w[A_W-1:0];
        b_sel = observer_position_gain;
      end
      STEP_INT: begin
        a_sel = err_w[A_W-1:0];
        b_sel = B_W'(time_step);
      end
      STEP_KP: begin
        a_sel = err_w[A_W-1:0];
        b_sel = position_gain;
      end
      STEP_KI: begin
        a_sel = A_W'(error_integral);
        b_sel = integral_gain;
      end
      STEP_KD: begin
        a_sel = A_W'(climb_rate);
        b_sel = velocity_gain;
      end
      STEP_MASS: begin
        a_sel = pid[A_W-1:0];
        b_sel = vehicle_mass;
      end
      default: begin
        a_sel = A_W'(climb_rate);
        b_sel = B_W'(time_step);
      end
    endcase
  end

  // One digit step: the running sum moves right by a digit each cycle, its low bits
  // collecting in lo. The rounding half is preloaded into hi.
  logic signed [SUM_W-1:0] a_ext;
  logic signed [SUM_W-1:0] d_ext;
  logic signed [SUM_W-1:0] mul_sum;

  assign a_ext   = SUM_W'(mul_a);
  assign d_ext   = SUM_W'($signed({1'b0, mul_b[DIGIT_W-1:0]}));
  assign mul_sum = SUM_W'(hi) + a_ext * d_ext;

  // Rounded product once all digits are in.
  logic signed [R_W-1:0]   res;
  logic signed [PID_W-1:0] res_w;

  assign res   = $signed({hi, lo}) >>> FRAC_BITS;
  assign res_w = PID_W'(res);

  logic signed [PID_W-1:0] accel_w;
  assign accel_w = res_w - PID_W'(GRAV_Q);

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        if (dig_cnt == CNT_W'(NDIG - 1)) begin
          state_next = ST_WB;
        end
      end
      ST_WB: begin
        if (step == STEP_MASS) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_LOAD;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_ZM;
    end else if (in_fire) begin
      step <= STEP_ZM;
    end else if (state == ST_WB && step != STEP_MASS) begin
      step <= step_t'(step + 4'd1);
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      position_gain          <= 24'd458752;
      integral_gain          <= 24'd58982;
      velocity_gain          <= 24'd288358;
      vehicle_mass           <= 24'd2530;
      inverse_mass           <= 24'd1698120;
      observer_position_gain <= 24'd4634;
      observer_velocity_gain <= 24'd32768;
      time_step              <= 16'd328;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POSITION_GAIN:          position_gain          <= cfg_data;
        REG_INTEGRAL_GAIN:          integral_gain          <= cfg_data;
        REG_VELOCITY_GAIN:          velocity_gain          <= cfg_data;
        REG_VEHICLE_MASS:           vehicle_mass           <= cfg_data;
        REG_INVERSE_MASS:           inverse_mass           <= cfg_data;
        REG_OBSERVER_POSITION_GAIN: observer_position_gain <= cfg_data;
        REG_OBSERVER_VELOCITY_GAIN: observer_velocity_gain <= cfg_data;
        REG_TIME_STEP:              time_step              <= cfg_data[DT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input capture and multiplier.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      range_q <= s_tdata[19:0];
      tilt_q  <= s_tdata[37:20];
      sp_q    <= s_tdata[58:38];
    end
    if (state == ST_LOAD) begin
      mul_a   <= a_sel;
      mul_b   <= b_sel;
      hi      <= HALF_HI;
      lo      <= '0;
      dig_cnt <= '0;
      if (step == STEP_ZM) begin
        ref_q <= ref_comb;
      end
    end else if (state == ST_MUL) begin
      hi      <= HI_W'(mul_sum >>> DIGIT_W);
      lo      <= {mul_sum[DIGIT_W-1:0], lo[B_W-1:DIGIT_W]};
      mul_b   <= mul_b >> DIGIT_W;
      dig_cnt <= dig_cnt + CNT_W'(1);
    end
  end

  // Write-back of each product into the working values.
  always_ff @(posedge clk) begin
    if (state == ST_WB) begin
      case (step)
        STEP_ZM:       zm    <= res[A_W-1:0];
        STEP_PRED_ACC: accel <= accel_w[A_W-1:0];
        STEP_KP:       pid   <= PID_W'(GRAV_Q) + res_w;
        STEP_KI:       pid   <= pid + res_w;
        STEP_KD:       pid   <= PID_W'(sat32(pid - res_w));
        STEP_MASS:     thrust_q <= sat24(res_w);
        default: begin
        end
      endcase
    end
  end

  // State that survives the tick is reset to zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      height          <= '0;
      climb_rate      <= '0;
      error_integral  <= '0;
      previous_thrust <= '0;
    end else if (state == ST_WB) begin
      case (step)
        STEP_PRED_H: height         <= sat32(PID_W'(height) + res_w);
        STEP_PRED_V: climb_rate     <= sat32(PID_W'(climb_rate) + res_w);
        STEP_COR_V:  climb_rate     <= sat32(PID_W'(climb_rate) + res_w);
        STEP_COR_H:  height         <= sat32(PID_W'(height) + res_w);
        STEP_INT:    error_integral <= sat32(PID_W'(error_integral) + res_w);
        STEP_MASS:   previous_thrust <= sat24(res_w);
        default: begin
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= {climb_rate, height, thrust_q};
    end
  end

`ifndef SYNTHESIS
  a_accept_starts_tick: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == ST_LOAD && step == STEP_ZM))
    else $error("accepted beat did not start a tick at its first product");

  a_digit_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> (dig_cnt <= CNT_W'(NDIG - 1)))
    else $error("digit counter ran past the last digit");

  a_last_product_ends_tick: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WB && step == STEP_MASS) |=> (state == ST_DONE))
    else $error("tick did not finish after the thrust product");

  a_result_only_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_DONE))
    else $error("result presented outside the hand-over cycle");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL || state == ST_WB) |-> !s_tready)
    else $error("input ready while a tick is in progress");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the altitude observer and PID thrust block.
`timescale 1ns / 1ps

// The bench drives control ticks into the block as stream beats and models each tick in
// 64-bit signed arithmetic. It queues the expected thrust and both estimates, and checks
// every output beat field by field against the oldest queued tick. A short directed
// table comes first. It covers the field extremes, the setpoint knee at half a metre
// and steady hover. Random phases follow, each under its own register setting: near the
// reset values, all ones, all zeros, random words, the reset values themselves, and a time
// step written with its upper byte set so that the masking of that register is exercised.
module tb_top;

  localparam int  F              = aopt_pkg::FRAC_BITS;
  localparam int  STALL_LIMIT    = 5000;  // cycles with no beat moving on either side
  localparam int  HOLD_AFTER     = 450;   // input beats before the long sink hold-off
  localparam int  HOLD_CYCLES    = 700;
  localparam int  TAIL_CYCLES    = 200;
  localparam int  N_PROBES       = 20;
  localparam int  MAX_REPORTS    = 100;

  localparam longint HALF_Q      = 64'sd1 <<< (F - 1);
  localparam longint GRAVITY_Q   = (64'sd981 * (64'sd1 <<< F) + 64'sd50) / 64'sd100;
  localparam longint S32_MAX     = 64'sd2147483647;
  localparam longint S32_MIN     = -64'sd2147483648;
  localparam longint THRUST_MAX  = 64'sd8388607;
  localparam longint THRUST_MIN  = -64'sd8388608;

  // Register values after reset, in register index order.
  localparam logic [23:0] RESET_REGS [8] = '{
    24'd458752, 24'd58982, 24'd288358, 24'd2530,
    24'd1698120, 24'd4634, 24'd32768, 24'd328
  };

  typedef enum int {
    CFG_RESET,
    CFG_NEAR,
    CFG_MAX,
    CFG_ZERO,
    CFG_WILD,
    CFG_WIDE_DT
  } cfg_kind_t;

  typedef struct {
    cfg_kind_t kind;
    int        items;
    bit        quiet;
  } phase_t;

  typedef struct packed {
    logic signed [23:0] thrust;
    logic signed [31:0] alt;
    logic signed [31:0] vel;
  } tick_out_t;

  typedef struct packed {
    logic        [19:0] rng;
    logic signed [17:0] tilt;
    logic signed [20:0] sp;
    logic               fixed_want;
    logic signed [23:0] thrust;
    logic signed [31:0] alt;
    logic signed [31:0] vel;
  } probe_row_t;

  // Directed ticks. Only the first one, straight after reset with all inputs at zero,
  // carries a hand-worked result: the height stays at zero, the climb rate falls by one
  // step of gravity, and the thrust is the mass times gravity plus the damping term.
  probe_row_t probe_rows [N_PROBES] = '{
    '{20'd0,      18'sd0,      21'sd0,      1'b1, 24'sd25366, 32'sd0, -32'sd3218},
    '{20'd655360, 18'sd65536,  21'sd655360, 1'b0, 24'sd0, 32'sd0, 32'sd0},
    '{20'hFFFFF,  18'sd131071, 21'sd1048575, 1'b0, 24'sd0, 32'sd0, 32'sd0},
    '{20'hFFFFF,  18'h20000,   21'h100000,  1'b0, 24'sd0, 32'sd0, 32'sd0},
    '{20'd327680, -18'sd65536, -21'sd655360, 1'b0, 24'sd0, 32'sd0, 32'sd0},
    '{20'd32768,  18'sd65536,  21'sd32768,  1'b0, 24'sd0, 32'sd0, 32'sd0},
    '{20'd32768,  18'sd65536,  21'sd32769,  1'b0, 24'sd0, 32'sd0, 32'sd0},
    '{20'd32768,  18'sd65536,  21'sd32772,  1'b0, 24'sd0, 32'sd0, 32'sd0},
    '{20'd0,      18'sd0,      21'sd0,      1'b0, 24'sd0, 32'sd0, 32'sd0},
    '{20'd65536,  18'sd1,      -21'sd1,     1'b0, 24'sd0, 32'sd0, 32'sd0},
    '{20'd1,      -18'sd1,     21'sd1,      1'b0, 24'sd0, 32'sd0, 32'sd0},
    '{20'd655360, 18'sd65536,  21'sd0,      1'b0, 24'sd0, 32'sd0, 32'sd0},
    '{20'd0,      18'sd65536,  21'sd655360, 1'b0, 24'sd0, 32'sd0, 32'sd0},
    '{20'hAAAAA,  18'h15555,   21'h0AAAAA,  1'b0, 24'sd0, 32'sd0, 32'sd0},
    '{20'h55555,  18'h2AAAA,   21'h155555,  1'b0, 24'sd0, 32'sd0, 32'sd0},
    '{20'd65536,  18'sd65536,  21'sd65536,  1'b0, 24'sd0, 32'sd0, 32'sd0},
    '{20'd65536,  18'sd65536,  21'sd65536,  1'b0, 24'sd0, 32'sd0, 32'sd0},
    '{20'd65536,  18'sd65536,  21'sd65536,  1'b0, 24'sd0, 32'sd0, 32'sd0},
    '{20'd65536,  18'sd65536,  21'sd65536,  1'b0, 24'sd0, 32'sd0, 32'sd0},
    '{20'd65536,  18'sd65536,  21'sd65536,  1'b0, 24'sd0, 32'sd0, 32'sd0}
  };

  // The first phase runs with no idling on either side; the long sink hold-off falls in
  // the second.
  phase_t phases [7] = '{
    '{CFG_NEAR,    300, 1'b1},
    '{CFG_NEAR,    300, 1'b0},
    '{CFG_MAX,      60, 1'b0},
    '{CFG_ZERO,     60, 1'b0},
    '{CFG_WILD,    150, 1'b0},
    '{CFG_RESET,   300, 1'b0},
    '{CFG_WIDE_DT, 230, 1'b0}
  };

  logic                          clk;
  logic                          rst       = 1'b1;
  logic                          s_tvalid  = 1'b0;
  logic                          s_tready;
  logic [aopt_pkg::IN_W-1:0]     s_tdata   = '0;
  logic                          m_tvalid;
  logic                          m_tready  = 1'b0;
  logic [aopt_pkg::OUT_W-1:0]    m_tdata;
  logic                          cfg_we    = 1'b0;
  logic [aopt_pkg::IDX_W-1:0]    cfg_index = '0;
  logic [aopt_pkg::GAIN_W-1:0]   cfg_data  = '0;

  // Shadow copy of the registers and of the observer and controller state.
  logic [23:0] cfg_shadow [8];
  longint      est_height   = 0;
  longint      est_climb    = 0;
  longint      err_integral = 0;
  longint      last_thrust  = 0;

  tick_out_t   expected_ticks [$];
  int          mismatch_count = 0;
  bit          quiet_run      = 1'b0;

  // Random walk that keeps most random ticks close to a hovering vehicle.
  int          hover_range    = 65536;
  int          goal_sp        = 65536;

  altitude_observer_pid_thrust i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Product of two fixed-point values, rounded half up by flooring after adding half an LSB.
  function automatic longint mul_round(input longint a, input longint b);
    return (a * b + HALF_Q) >>> F;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint reg_value(input logic [2:0] idx);
    return longint'(cfg_shadow[idx]);
  endfunction

  // One control tick: shape the setpoint, predict, correct, then run the PID law.
  function automatic tick_out_t advance_tick(input logic [19:0] rng,
                                             input logic signed [17:0] tilt,
                                             input logic signed [20:0] sp);
    longint    dt;
    longint    goal;
    longint    zm;
    longint    h_pred;
    longint    acc;
    longint    innov;
    longint    err;
    longint    pid;
    longint    thr;
    tick_out_t res;
    dt = reg_value(aopt_pkg::REG_TIME_STEP);
    // Above half a metre the excess of the commanded altitude is divided by five.
    if (longint'(sp) > HALF_Q) begin
      goal = HALF_Q + (longint'(sp) - HALF_Q) / 5;
    end else begin
      goal = longint'(sp);
    end
    zm = mul_round(longint'(rng), longint'(tilt));

    h_pred = clamp(est_height + mul_round(est_climb, dt), S32_MIN, S32_MAX);
    acc = mul_round(last_thrust, reg_value(aopt_pkg::REG_INVERSE_MASS)) - GRAVITY_Q;
    est_climb = clamp(est_climb + mul_round(acc, dt), S32_MIN, S32_MAX);
    est_height = h_pred;

    innov = zm - est_height;
    est_climb = clamp(est_climb + mul_round(reg_value(aopt_pkg::REG_OBSERVER_VELOCITY_GAIN),
                                            innov), S32_MIN, S32_MAX);
    est_height = clamp(est_height + mul_round(reg_value(aopt_pkg::REG_OBSERVER_POSITION_GAIN),
                                              innov), S32_MIN, S32_MAX);

    err = goal - est_height;
    err_integral = clamp(err_integral + mul_round(err, dt), S32_MIN, S32_MAX);
    pid = GRAVITY_Q + mul_round(reg_value(aopt_pkg::REG_POSITION_GAIN), err)
        + mul_round(reg_value(aopt_pkg::REG_INTEGRAL_GAIN), err_integral)
        - mul_round(reg_value(aopt_pkg::REG_VELOCITY_GAIN), est_climb);
    pid = clamp(pid, S32_MIN, S32_MAX);
    thr = clamp(mul_round(reg_value(aopt_pkg::REG_VEHICLE_MASS), pid), THRUST_MIN, THRUST_MAX);
    last_thrust = thr;

    res.thrust = thr[23:0];
    res.alt    = est_height[31:0];
    res.vel    = est_climb[31:0];
    return res;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // Present one beat and hold it until the block takes it. Valid stays high on return, so
  // the caller either offers the next beat or lowers it, never both in one step.
  task automatic offer_beat(input logic [19:0] rng, input logic signed [17:0] tilt,
                            input logic signed [20:0] sp);
    s_tdata  <= {5'd0, sp, tilt, rng};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (s_tready !== 1'b1);
  endtask

  // Occasional sender gap of random length, so that gaps land on every step of a tick.
  task automatic sender_gap();
    if (!quiet_run && $urandom_range(0, 99) < 20) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 120)) @(posedge clk);
    end
  endtask

  // Stop offering beats until every queued tick has come back.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_ticks.size() != 0);
    @(posedge clk);
  endtask

  // Write all eight registers with one kind of setting; the block is idle by now.
  task automatic load_settings(input cfg_kind_t kind);
    logic [23:0] value;
    for (int i = 0; i < 8; i++) begin
      case (kind)
        CFG_RESET: begin
          value = RESET_REGS[i];
        end
        CFG_MAX: begin
          value = 24'hFF_FFFF;
        end
        CFG_ZERO: begin
          value = 24'd0;
        end
        CFG_WILD: begin
          value = 24'($urandom());
        end
        default: begin
          value = 24'((longint'(RESET_REGS[i]) * $urandom_range(75, 125)) / 100);
          if (kind == CFG_WIDE_DT && i == aopt_pkg::REG_TIME_STEP) begin
            value[23:16] = 8'($urandom_range(1, 255));
          end
        end
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= aopt_pkg::IDX_W'(i);
      cfg_data  <= value;
      @(posedge clk);
      // The time step register keeps only its lower sixteen bits.
      cfg_shadow[i] = (i == aopt_pkg::REG_TIME_STEP) ? (value & 24'h00_FFFF) : value;
    end
    cfg_we <= 1'b0;
  endtask

  // Random tick: mostly a vehicle near hover with a drifting setpoint, the rest raw noise
  // over the full field widths or picks from the field extremes.
  task automatic make_tick(output logic [19:0] rng, output logic signed [17:0] tilt,
                           output logic signed [20:0] sp);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      if ($urandom_range(0, 99) < 3) begin
        if ($urandom_range(0, 9) < 6) begin
          goal_sp = $urandom_range(0, 131072);
        end else begin
          goal_sp = int'($urandom_range(0, 1310720)) - 655360;
        end
      end
      hover_range = hover_range + int'($urandom_range(0, 6000)) - 3000;
      if (hover_range < 0) begin
        hover_range = 0;
      end else if (hover_range > 655360) begin
        hover_range = 655360;
      end
      rng = 20'(hover_range);
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        tilt = 18'(65536 - int'($urandom_range(0, 8000)));
      end else if (pick < 9) begin
        tilt = 18'($urandom_range(0, 65536));
      end else begin
        tilt = 18'(-int'($urandom_range(0, 65536)));
      end
      sp = 21'(goal_sp);
    end else if (pick < 92) begin
      rng  = 20'($urandom());
      tilt = 18'($urandom());
      sp   = 21'($urandom());
    end else begin
      case ($urandom_range(0, 2))
        0:       rng = 20'd0;
        1:       rng = 20'd655360;
        default: rng = 20'hFFFFF;
      endcase
      case ($urandom_range(0, 4))
        0:       tilt = -18'sd65536;
        1:       tilt = 18'sd65536;
        2:       tilt = 18'sd131071;
        3:       tilt = 18'h20000;
        default: tilt = 18'sd0;
      endcase
      case ($urandom_range(0, 5))
        0:       sp = 21'sd32768;
        1:       sp = 21'sd32769;
        2:       sp = 21'sd655360;
        3:       sp = -21'sd655360;
        4:       sp = 21'sd1048575;
        default: sp = 21'h100000;
      endcase
    end
  endtask

  // Sink side: random back-pressure, none in the quiet phase, and one long hold-off once
  // enough input beats have gone in, so that the block fills and stalls its input.
  int beats_in  = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      beats_in++;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!hold_done && beats_in >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= quiet_run ? 1'b1 : ($urandom_range(0, 99) >= 13);
    end
  end

  // Output checker: each accepted beat is compared with the oldest queued tick.
  int beats_out = 0;

  always @(posedge clk) begin
    tick_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_ticks.size() == 0) begin
        note_mismatch($sformatf("output beat %0d with no tick queued", beats_out));
      end else begin
        want = expected_ticks.pop_front();
        if (m_tdata[23:0] !== want.thrust) begin
          note_mismatch($sformatf("beat %0d thrust got %0d want %0d", beats_out,
                                  $signed(m_tdata[23:0]), want.thrust));
        end
        if (m_tdata[55:24] !== want.alt) begin
          note_mismatch($sformatf("beat %0d altitude got %0d want %0d", beats_out,
                                  $signed(m_tdata[55:24]), want.alt));
        end
        if (m_tdata[87:56] !== want.vel) begin
          note_mismatch($sformatf("beat %0d velocity got %0d want %0d", beats_out,
                                  $signed(m_tdata[87:56]), want.vel));
        end
      end
      beats_out++;
    end
  end

  // Watchdog: too long without a beat moving on either side means the block has hung.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL altitude_observer_pid_thrust");
        $finish;
      end
    end
  end

  initial begin
    logic        [19:0] rng;
    logic signed [17:0] tilt;
    logic signed [20:0] sp;
    tick_out_t          forecast;
    cfg_shadow = RESET_REGS;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed ticks under the reset register values.
    for (int r = 0; r < N_PROBES; r++) begin
      sender_gap();
      offer_beat(probe_rows[r].rng, probe_rows[r].tilt, probe_rows[r].sp);
      forecast = advance_tick(probe_rows[r].rng, probe_rows[r].tilt, probe_rows[r].sp);
      if (probe_rows[r].fixed_want) begin
        expected_ticks.push_back({probe_rows[r].thrust, probe_rows[r].alt,
                                  probe_rows[r].vel});
      end else begin
        expected_ticks.push_back(forecast);
      end
    end

    // Random phases; the sender waits for every result before each register change.
    foreach (phases[p]) begin
      drain_results();
      load_settings(phases[p].kind);
      quiet_run = phases[p].quiet;
      for (int n = 0; n < phases[p].items; n++) begin
        sender_gap();
        make_tick(rng, tilt, sp);
        offer_beat(rng, tilt, sp);
        expected_ticks.push_back(advance_tick(rng, tilt, sp));
      end
      quiet_run = 1'b0;
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_ticks.size() != 0) begin
      note_mismatch($sformatf("%0d ticks never came back", expected_ticks.size()));
    end
    if (mismatch_count == 0) begin
      $display("PASS altitude_observer_pid_thrust");
    end else begin
      $display("FAIL altitude_observer_pid_thrust");
    end
    $finish;
  end

endmodule
